// ===== rtl/nvar_pkg.sv =====
package nvar_pkg;

	// fixed field widths
	localparam int DIM_W   = 12;
	localparam int CFG_W   = 12;
	localparam int IDX_W   = 2;
	localparam int ANGLE_W = 9;
	localparam int DEST_W  = 22;
	localparam int WORD_W  = 32;
	localparam int CHAN_W  = 8;

	// default frame limits
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// register reset values
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// angle limits and quadrant edges in degrees
	localparam int ANGLE_LIMIT = 180;
	localparam int ANGLE_EDGE1 = 45;
	localparam int ANGLE_EDGE3 = 135;

	localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_ANGLE  = 2'd2;

	typedef enum logic [1:0] {
		ROT_UPRIGHT,
		ROT_QUARTER,
		ROT_HALF,
		ROT_SWAPPED
	} rot_mode_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		rot_mode_t        mode;
	} frame_cfg_t;

	function automatic rot_mode_t mode_of_angle(logic signed [ANGLE_W-1:0] a);
		rot_mode_t m;
		if (a > -ANGLE_EDGE1 && a <= ANGLE_EDGE1) begin
			m = ROT_UPRIGHT;
		end else if (a > ANGLE_EDGE1 && a <= ANGLE_EDGE3) begin
			m = ROT_QUARTER;
		end else if (a > -ANGLE_EDGE3 && a <= -ANGLE_EDGE1) begin
			m = ROT_SWAPPED;
		end else begin
			m = ROT_HALF;
		end
		return m;
	endfunction

endpackage

// ===== rtl/nv21_to_argb_rotate_unit.sv =====
// nv21 camera pixel to argb8888 converter with rotation. pixels enter in raster order of the
// source frame, each with its luma byte and the chroma pair of its 2x2 block, and leave as an
// opaque 32-bit color word plus the pixel's linear index in the rotated output frame and a
// flag on the frame's final pixel. one pixel is taken every clock unless a waiting result
// stalls; each request passes the input register and then the result register, with the
// color sums, clamps and the 12x12 index multiplier between them. the size registers are
// clamped to 2..MAX and made even; writing either restarts the frame. angle writes outside
// -180..180 are dropped. write configuration only while the pipe is empty.
module nv21_to_argb_rotate_unit
	import nvar_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_write,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// pixel requests
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAN_W-1:0] luma,
	input  logic [CHAN_W-1:0] chroma_first,
	input  logic [CHAN_W-1:0] chroma_second,
	// results
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] pixel_word,
	output logic [DEST_W-1:0] dest_index,
	output logic              frame_last
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	frame_cfg_t        cfg;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic              last;
	logic              accept;
	logic              advance;

	// input stage
	logic              valid_s1;
	logic [CHAN_W-1:0] luma_s1;
	logic [CHAN_W-1:0] chroma_first_s1;
	logic [CHAN_W-1:0] chroma_second_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              last_s1;

	// result stage
	logic              valid_s2;
	logic [WORD_W-1:0] pixel_word_s2;
	logic [DEST_W-1:0] dest_index_s2;
	logic              frame_last_s2;

	logic [WORD_W-1:0] word_calc;
	logic [DEST_W-1:0] dest_calc;

	// the result register frees up when empty or taken; the input register then follows
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// registers, source position counters and end-of-frame detect
	nvar_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (accept),
		.cfg      (cfg),
		.col      (col),
		.row      (row),
		.last     (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// capture the pixel with its source position
	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1          <= luma;
			chroma_first_s1  <= chroma_first;
			chroma_second_s1 <= chroma_second;
			col_s1           <= col;
			row_s1           <= row;
			last_s1          <= last;
		end
	end

	// color conversion, channel order follows the rotation mode
	nvar_color u_color (
		.luma         (luma_s1),
		.chroma_first (chroma_first_s1),
		.chroma_second(chroma_second_s1),
		.swapped      (cfg.mode == ROT_SWAPPED),
		.word         (word_calc)
	);

	// destination index, one multiply and add
	nvar_index #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_index (
		.mode  (cfg.mode),
		.width (cfg.width),
		.height(cfg.height),
		.col   (col_s1),
		.row   (row_s1),
		.dest  (dest_calc)
	);

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pixel_word_s2 <= word_calc;
			dest_index_s2 <= dest_calc;
			frame_last_s2 <= last_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign pixel_word = pixel_word_s2;
	assign dest_index = dest_index_s2;
	assign frame_last = frame_last_s2;

endmodule

// ===== rtl/nvar_ctrl.sv =====
module nvar_ctrl
	import nvar_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             step,
	output frame_cfg_t       cfg,
	output logic [COL_W-1:0] col,
	output logic [ROW_W-1:0] row,
	output logic             last
);

	function automatic logic [DIM_W-1:0] fit_size(logic [CFG_W-1:0] v, int max_size);
		logic [DIM_W-1:0] s;
		s = v;
		if (s < 2) begin
			s = DIM_W'(2);
		end
		if (32'(s) > max_size) begin
			s = DIM_W'(max_size);
		end
		return s & ~DIM_W'(1);
	endfunction

	frame_cfg_t                  cfg_q;
	logic [COL_W-1:0]            col_q;
	logic [ROW_W-1:0]            row_q;
	logic signed [ANGLE_W-1:0]   angle_in;
	logic [DIM_W:0]              col_inc;
	logic [DIM_W:0]              row_inc;
	logic                        wrap_col;
	logic                        wrap_row;

	assign angle_in = cfg_data[ANGLE_W-1:0];

	assign col_inc  = (DIM_W+1)'(col_q) + (DIM_W+1)'(1);
	assign row_inc  = (DIM_W+1)'(row_q) + (DIM_W+1)'(1);
	assign wrap_col = col_inc >= {1'b0, cfg_q.width};
	assign wrap_row = row_inc >= {1'b0, cfg_q.height};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= fit_size(CFG_W'(RESET_WIDTH), MAX_WIDTH);
			cfg_q.height <= fit_size(CFG_W'(RESET_HEIGHT), MAX_HEIGHT);
			cfg_q.mode   <= ROT_UPRIGHT;
			col_q        <= '0;
			row_q        <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					cfg_q.width <= fit_size(cfg_data, MAX_WIDTH);
					col_q       <= '0;
					row_q       <= '0;
				end
				REG_HEIGHT: begin
					cfg_q.height <= fit_size(cfg_data, MAX_HEIGHT);
					col_q        <= '0;
					row_q        <= '0;
				end
				REG_ANGLE: begin
					if (angle_in >= -ANGLE_LIMIT && angle_in <= ANGLE_LIMIT) begin
						cfg_q.mode <= mode_of_angle(angle_in);
					end
				end
				default: begin
				end
			endcase
		end else if (step) begin
			if (wrap_col) begin
				col_q <= '0;
				row_q <= wrap_row ? '0 : ROW_W'(row_inc);
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

	assign cfg  = cfg_q;
	assign col  = col_q;
	assign row  = row_q;
	assign last = wrap_col && wrap_row;

endmodule

// ===== rtl/nvar_color.sv =====
module nvar_color
	import nvar_pkg::*;
(
	input  logic [CHAN_W-1:0] luma,
	input  logic [CHAN_W-1:0] chroma_first,
	input  logic [CHAN_W-1:0] chroma_second,
	input  logic              swapped,
	output logic [WORD_W-1:0] word
);

	function automatic logic [CHAN_W-1:0] clamp8(logic signed [10:0] v);
		logic [CHAN_W-1:0] c;
		if (v < 0) begin
			c = '0;
		end else if (v > 255) begin
			c = '1;
		end else begin
			c = v[CHAN_W-1:0];
		end
		return c;
	endfunction

	logic signed [CHAN_W-1:0] p;
	logic signed [CHAN_W-1:0] q;
	logic signed [CHAN_W-1:0] cr;
	logic signed [CHAN_W-1:0] cb;
	logic signed [10:0]       y_x;
	logic signed [10:0]       cr_x;
	logic signed [10:0]       cb_x;
	logic signed [10:0]       r_sum;
	logic signed [10:0]       g_sum;
	logic signed [10:0]       b_sum;
	logic [CHAN_W-1:0]        r;
	logic [CHAN_W-1:0]        g;
	logic [CHAN_W-1:0]        b;

	// byte minus 128 is the byte with its top bit flipped
	assign p  = {~chroma_first[7], chroma_first[6:0]};
	assign q  = {~chroma_second[7], chroma_second[6:0]};
	assign cr = swapped ? q : p;
	assign cb = swapped ? p : q;

	assign y_x  = {3'b000, luma};
	assign cr_x = {{3{cr[7]}}, cr};
	assign cb_x = {{3{cb[7]}}, cb};

	assign r_sum = y_x + cr_x + (cr_x >>> 2) + (cr_x >>> 3) + (cr_x >>> 5);
	assign g_sum = y_x - (cb_x >>> 2) + (cb_x >>> 4) + (cb_x >>> 5)
	             - (cr_x >>> 1) + (cr_x >>> 3) + (cr_x >>> 4) + (cr_x >>> 5);
	assign b_sum = y_x + cb_x + (cb_x >>> 1) + (cb_x >>> 2) + (cb_x >>> 6);

	assign r = clamp8(r_sum);
	assign g = clamp8(g_sum);
	assign b = clamp8(b_sum);

	assign word = swapped ? {ALPHA, b, g, r} : {ALPHA, r, g, b};

endmodule

// ===== rtl/nvar_index.sv =====
module nvar_index
	import nvar_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
	input  rot_mode_t         mode,
	input  logic [DIM_W-1:0]  width,
	input  logic [DIM_W-1:0]  height,
	input  logic [COL_W-1:0]  col,
	input  logic [ROW_W-1:0]  row,
	output logic [DEST_W-1:0] dest
);

	logic [DIM_W-1:0]   i;
	logic [DIM_W-1:0]   j;
	logic [DIM_W-1:0]   inv_i;
	logic [DIM_W-1:0]   inv_j;
	logic [DIM_W-1:0]   mul_a;
	logic [DIM_W-1:0]   mul_b;
	logic [DIM_W-1:0]   addend;
	logic [2*DIM_W-1:0] product;

	assign i     = DIM_W'(col);
	assign j     = DIM_W'(row);
	assign inv_i = width - DIM_W'(1) - i;
	assign inv_j = height - DIM_W'(1) - j;

	always_comb begin
		unique case (mode)
			ROT_UPRIGHT: begin
				mul_a  = i;
				mul_b  = height;
				addend = inv_j;
			end
			ROT_QUARTER: begin
				mul_a  = inv_j;
				mul_b  = width;
				addend = inv_i;
			end
			ROT_HALF: begin
				mul_a  = inv_i;
				mul_b  = height;
				addend = j;
			end
			ROT_SWAPPED: begin
				mul_a  = j;
				mul_b  = width;
				addend = i;
			end
		endcase
	end

	assign product = mul_a * mul_b;
	assign dest    = DEST_W'(product) + DEST_W'(addend);

endmodule

// ===== rtl/nvar_checker.sv =====
module nvar_checker
	import nvar_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] pixel_word,
	input logic [DEST_W-1:0] dest_index,
	input logic              frame_last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_word)
			&& $stable(dest_index) && $stable(frame_last))
		else $error("stalled result changed");

	// every result is opaque
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_word[31:24] == ALPHA)
		else $error("alpha byte not 0xff");

	// an empty result register never blocks requests
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request blocked with empty output");

	// an accepted request reaches the output or waits behind a stalled result
	a_request_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted request lost");

endmodule

bind nv21_to_argb_rotate_unit nvar_checker u_nvar_checker (.*);
